// ----- design/pfd_pkg.sv -----
package pfd_pkg;

  // Square geometry
  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int ALPHA     = 26;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int IDX_W     = $clog2(ALPHA);

  localparam logic [IDX_W-1:0] IDX_I    = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_J    = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHA - 1);
  localparam logic [2:0]       SIDE_M1  = 3'(SIDE - 1);

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [6:0] OUT_A    = 7'h41;

  // Input command codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_KEY    = 2'd1,
    OP_FINISH = 2'd2,
    OP_CIPHER = 2'd3
  } pfd_op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] letter;
  } pfd_in_t;

  typedef struct packed {
    logic [6:0] plain_letter;
    logic       last_of_pair;
  } pfd_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;
    logic key;
    logic hold;
    logic pair;
    logic fill_start;
    logic fill_step;
    logic look_b;
    logic calc;
    logic read2;
    logic cap;
    logic load2;
  } pfd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    pfd_op_t op;
    logic    letter_ok;
    logic    held_valid;
    logic    fill_done;
  } pfd_stat_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } pfd_lidx_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } pfd_rc_t;

  // ASCII byte to letter index, lowercase folded, J folded to I
  function automatic pfd_lidx_t letter_idx(input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    pfd_lidx_t  r;
    c = b;
    if (c >= CH_LA && c <= CH_LZ) c = c - CASE_OFS;
    d = c - CH_A;
    r.ok  = (c >= CH_A) && (c <= CH_Z);
    r.idx = d[IDX_W-1:0];
    if (r.idx == IDX_J) r.idx = IDX_I;
    return r;
  endfunction

  // Cell number to row and column
  function automatic pfd_rc_t cell_rc(input logic [CELL_W-1:0] p);
    pfd_rc_t          r;
    logic [CELL_W-1:0] base;
    if (p >= CELL_W'(4 * SIDE))      r.row = 3'd4;
    else if (p >= CELL_W'(3 * SIDE)) r.row = 3'd3;
    else if (p >= CELL_W'(2 * SIDE)) r.row = 3'd2;
    else if (p >= CELL_W'(SIDE))     r.row = 3'd1;
    else                             r.row = 3'd0;
    base  = {r.row[CELL_W-3:0], 2'b00} + CELL_W'(r.row);
    base  = p - base;
    r.col = base[2:0];
    return r;
  endfunction

  // Row and column to cell number
  function automatic logic [CELL_W-1:0] rc_cell(input logic [2:0] row, input logic [2:0] col);
    return {row[CELL_W-3:0], 2'b00} + CELL_W'(row) + CELL_W'(col);
  endfunction

  // Wrapping step back by one
  function automatic logic [2:0] wrap_dec(input logic [2:0] v);
    return (v == 3'd0) ? SIDE_M1 : v - 3'd1;
  endfunction

endpackage

// ----- design/playfair_decrypt_top.sv -----
// Channel | Signals                          | Word
// --------+----------------------------------+----------------------------------
// input   | in_valid, in_ready, in_data      | command, letter
// output  | out_valid, out_ready, out_data   | plain_letter, last_of_pair
//
// Clear, key letter, first cipher letter and ignored bytes are handled in idle.
// Finish key walks the alphabet one letter per cycle, placing each not yet taken.
// A cipher pair runs LOOKB, CALC, READ1, READ2, CAP to its first result word:
// two lookups in the letter-to-cell RAM, two in the square RAM, one read port each.
// in_ready is high only while idle; a stalled output holds the block.
// Reset (rst_n, synchronous) empties the key; the square RAMs need no clearing.
module playfair_decrypt_top import pfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pfd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pfd_out_t out_data
);

  pfd_cmd_t  cmd;
  pfd_stat_t stat;

  pfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfd_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // no input taken while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // first word of a pair is always followed by the second
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_pair) |=>
      (out_valid && out_data.last_of_pair))
    else $error("second word of pair missing");

  // a pair opens with its first word
  a_pair_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_data.last_of_pair)
    else $error("pair opened with last word");

  // a finished alphabet walk returns the controller to idle
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fill_step && stat.fill_done) |=> in_ready)
    else $error("alphabet walk did not return to idle");

endmodule

// ----- design/pfd_ram.sv -----
module pfd_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pfd_ctrl.sv -----
module pfd_ctrl import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pfd_stat_t stat,
  output pfd_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FILL  = 9'b000000010,
    S_LOOKB = 9'b000000100,
    S_CALC  = 9'b000001000,
    S_READ1 = 9'b000010000,
    S_READ2 = 9'b000100000,
    S_CAP   = 9'b001000000,
    S_EMIT1 = 9'b010000000,
    S_EMIT2 = 9'b100000000
  } pfd_state_t;

  pfd_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT1) || (state_r == S_EMIT2);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (stat.op)
            OP_CLEAR:  cmd.clear = 1'b1;
            OP_KEY:    cmd.key   = stat.letter_ok;
            OP_FINISH: begin
              cmd.fill_start = 1'b1;
              state_nxt      = S_FILL;
            end
            OP_CIPHER: begin
              if (stat.letter_ok) begin
                if (stat.held_valid) begin
                  cmd.pair  = 1'b1;
                  state_nxt = S_LOOKB;
                end else begin
                  cmd.hold = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_done) state_nxt = S_IDLE;
      end
      S_LOOKB: begin
        cmd.look_b = 1'b1;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_READ1;
      end
      S_READ1: state_nxt = S_READ2;
      S_READ2: begin
        cmd.read2 = 1'b1;
        state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_EMIT1;
      end
      S_EMIT1: begin
        if (out_ready) begin
          cmd.load2 = 1'b1;
          state_nxt = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- design/pfd_dpath.sv -----
module pfd_dpath import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pfd_in_t   in_data,
  input  pfd_cmd_t  cmd,
  output pfd_stat_t stat,
  output pfd_out_t  out_data
);

  logic [ALPHA-1:0]  taken_r;
  logic [CELL_W-1:0] fill_r;
  logic [IDX_W-1:0]  fc_r;
  logic [IDX_W-1:0]  held_r;
  logic              held_valid_r;
  logic [IDX_W-1:0]  b_r;
  logic [CELL_W-1:0] pa_r;
  logic [CELL_W-1:0] p1_r, p2_r;
  logic [IDX_W-1:0]  o1_r;
  pfd_out_t          out_r;

  pfd_lidx_t         li;
  logic [IDX_W-1:0]  place_idx;
  logic              place_en;
  logic [CELL_W-1:0] place_rdata;
  logic [IDX_W-1:0]  place_raddr;
  logic [IDX_W-1:0]  sq_rdata;
  logic [CELL_W-1:0] sq_raddr;
  logic [CELL_W-1:0] pb;
  pfd_rc_t           rc1, rc2;
  logic [CELL_W-1:0] q1, q2;

  assign li = letter_idx(in_data.letter);

  assign stat.op         = pfd_op_t'(in_data.command);
  assign stat.letter_ok  = li.ok;
  assign stat.held_valid = held_valid_r;
  assign stat.fill_done  = (fc_r == IDX_LAST);

  // letter placement: key letter or one step of the alphabet walk
  assign place_idx = cmd.fill_step ? fc_r : li.idx;
  assign place_en  = (cmd.key || (cmd.fill_step && fc_r != IDX_J))
                     && !taken_r[place_idx] && (fill_r < CELL_W'(CELLS));

  // square: cell -> letter
  pfd_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_square (
    .clk   (clk),
    .we    (place_en),
    .waddr (fill_r),
    .wdata (place_idx),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // place: letter -> cell
  pfd_ram #(.WIDTH(CELL_W), .DEPTH(ALPHA)) u_place (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_idx),
    .wdata (fill_r),
    .raddr (place_raddr),
    .rdata (place_rdata)
  );

  assign place_raddr = cmd.look_b ? b_r : held_r;
  assign sq_raddr    = cmd.read2 ? p2_r : p1_r;

  // second letter's cell, zero when not in the square
  assign pb = taken_r[b_r] ? place_rdata : '0;

  // pair rule
  always_comb begin
    rc1 = cell_rc(pa_r);
    rc2 = cell_rc(pb);
    if (rc1.row == rc2.row) begin
      q1 = rc_cell(rc1.row, wrap_dec(rc1.col));
      q2 = rc_cell(rc2.row, wrap_dec(rc2.col));
    end else if (rc1.col == rc2.col) begin
      q1 = rc_cell(wrap_dec(rc1.row), rc1.col);
      q2 = rc_cell(wrap_dec(rc2.row), rc2.col);
    end else begin
      q1 = rc_cell(rc1.row, rc2.col);
      q2 = rc_cell(rc2.row, rc1.col);
    end
  end

  // key state and held letter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r      <= '0;
      fill_r       <= '0;
      fc_r         <= '0;
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        taken_r      <= '0;
        fill_r       <= '0;
        held_r       <= '0;
        held_valid_r <= 1'b0;
      end
      if (place_en) begin
        taken_r[place_idx] <= 1'b1;
        fill_r             <= fill_r + CELL_W'(1);
      end
      if (cmd.fill_start)     fc_r <= '0;
      else if (cmd.fill_step) fc_r <= fc_r + IDX_W'(1);
      if (cmd.hold) begin
        held_r       <= li.idx;
        held_valid_r <= 1'b1;
      end
      if (cmd.pair) held_valid_r <= 1'b0;
    end
  end

  // pair pipeline and result word
  always_ff @(posedge clk) begin
    if (cmd.pair)   b_r  <= li.idx;
    if (cmd.look_b) pa_r <= taken_r[held_r] ? place_rdata : '0;
    if (cmd.calc) begin
      p1_r <= q1;
      p2_r <= q2;
    end
    if (cmd.read2) o1_r <= sq_rdata;
    if (cmd.cap) begin
      out_r.plain_letter <= OUT_A + 7'(o1_r);
      out_r.last_of_pair <= 1'b0;
      o1_r               <= sq_rdata;
    end
    if (cmd.load2) begin
      out_r.plain_letter <= OUT_A + 7'(o1_r);
      out_r.last_of_pair <= 1'b1;
    end
  end

  assign out_data = out_r;

endmodule

// ----- tb/tb_playfair_decrypt_top.sv -----
`timescale 1ns / 100ps

module tb_playfair_decrypt_top;
  import pfd_pkg::*;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pfd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  pfd_out_t out_data;

  // Mirror of the key square and cipher pair state
  logic [IDX_W-1:0]  sq_letter   [CELLS];
  logic [CELL_W-1:0] letter_cell [ALPHA];
  logic [ALPHA-1:0]  in_square = '0;
  int                filled    = 0;
  logic [IDX_W-1:0]  held_idx  = '0;
  bit                held_ok   = 1'b0;

  // Plaintext words still to come, oldest first
  pfd_out_t plain_q[$];
  pfd_out_t due_w;

  int err_count  = 0;
  int words_sent = 0;
  bit send_idle  = 1'b0;
  bit sink_stall = 1'b0;
  int stall_left = 0;

  playfair_decrypt_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // ASCII byte to letter index, J folded into I; -1 for a non-letter
  function automatic int fold_letter(input logic [7:0] ch);
    logic [7:0] u;
    u = ch;
    if (u >= CH_LA && u <= CH_LZ) u = u - CASE_OFS;
    if (u < CH_A || u > CH_Z) return -1;
    u = u - CH_A;
    if (u == 8'(IDX_J)) return int'(IDX_I);
    return int'(u);
  endfunction

  function automatic void place_key_letter(input int idx);
    if (filled >= CELLS || in_square[idx]) return;
    sq_letter[filled]  = IDX_W'(idx);
    letter_cell[idx]   = CELL_W'(filled);
    in_square[idx]     = 1'b1;
    filled++;
  endfunction

  // Letters missing from the square sit at cell 0
  function automatic int cell_of_letter(input int idx);
    return in_square[idx] ? int'(letter_cell[idx]) : 0;
  endfunction

  function automatic pfd_out_t plain_word(input int row, input int col, input bit last);
    pfd_out_t w;
    w.plain_letter = OUT_A + 7'(sq_letter[(row % SIDE) * SIDE + (col % SIDE)]);
    w.last_of_pair = last;
    return w;
  endfunction

  // Advance the mirror by one accepted word, queue any plaintext it yields
  function automatic void decrypt_word(input pfd_in_t w);
    int idx, pa, pb, r1, c1, r2, c2;
    idx = fold_letter(w.letter);
    case (pfd_op_t'(w.command))
      OP_CLEAR: begin
        in_square = '0;
        filled    = 0;
        held_ok   = 1'b0;
        held_idx  = '0;
      end
      OP_FINISH: begin
        for (int c = 0; c < ALPHA; c++)
          if (c != int'(IDX_J)) place_key_letter(c);
      end
      OP_KEY: begin
        if (idx >= 0) place_key_letter(idx);
      end
      OP_CIPHER: begin
        if (idx >= 0 && !held_ok) begin
          held_idx = IDX_W'(idx);
          held_ok  = 1'b1;
        end else if (idx >= 0) begin
          held_ok = 1'b0;
          pa = cell_of_letter(int'(held_idx));
          pb = cell_of_letter(idx);
          r1 = pa / SIDE;
          c1 = pa % SIDE;
          r2 = pb / SIDE;
          c2 = pb % SIDE;
          if (r1 == r2) begin
            plain_q.push_back(plain_word(r1, c1 + SIDE - 1, 1'b0));
            plain_q.push_back(plain_word(r2, c2 + SIDE - 1, 1'b1));
          end else if (c1 == c2) begin
            plain_q.push_back(plain_word(r1 + SIDE - 1, c1, 1'b0));
            plain_q.push_back(plain_word(r2 + SIDE - 1, c2, 1'b1));
          end else begin
            plain_q.push_back(plain_word(r1, c2, 1'b0));
            plain_q.push_back(plain_word(r2, c1, 1'b1));
          end
        end
      end
    endcase
  endfunction

  // Drive one word, hold it until taken, then update the mirror
  task automatic send_word(input pfd_op_t op, input logic [7:0] ch);
    pfd_in_t w;
    w.command = op;
    w.letter  = ch;
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decrypt_word(w);
    words_sent++;
  endtask

  // Letter byte in random case; I is sometimes written as J
  function automatic logic [7:0] letter_byte(input int idx);
    logic [7:0] ch;
    ch = CH_A + 8'(idx);
    if (idx == int'(IDX_I) && $urandom_range(0, 2) == 0) ch = CH_A + 8'(IDX_J);
    if ($urandom_range(0, 1) == 1) ch = ch + CASE_OFS;
    return ch;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(0, 255)); while (fold_letter(ch) >= 0);
    return ch;
  endfunction

  // Mostly letters present in the square, now and then any letter
  function automatic int square_pick();
    int idx;
    idx = $urandom_range(0, ALPHA - 1);
    if (filled == 0 || $urandom_range(0, 7) == 0) return idx;
    while (!in_square[idx]) idx = $urandom_range(0, ALPHA - 1);
    return idx;
  endfunction

  // Plain alphabet square; every cell gets written before any decrypt
  task automatic test_alphabet_square();
    send_word(OP_FINISH, 8'h00);
    send_word(OP_CIPHER, "A");  // same row, wraps to the right end
    send_word(OP_CIPHER, "B");
    send_word(OP_CIPHER, "a");  // same column, wraps to the bottom
    send_word(OP_CIPHER, "f");
    send_word(OP_CIPHER, "G");  // rectangle
    send_word(OP_CIPHER, "z");
    send_word(OP_CIPHER, "E");  // doubled letter
    send_word(OP_CIPHER, "E");
    send_word(OP_CIPHER, "j");  // J read as I
    send_word(OP_CIPHER, "K");
  endtask

  // Keyword square: repeats, J folding, junk bytes, full-square cases
  task automatic test_keyed_square();
    send_word(OP_CLEAR, 8'hff);
    send_word(OP_KEY, "P");
    send_word(OP_KEY, "l");
    send_word(OP_KEY, "a");
    send_word(OP_KEY, "J");
    send_word(OP_KEY, "i");     // repeat of I through folding
    send_word(OP_KEY, " ");
    send_word(OP_FINISH, 8'h55);
    send_word(OP_FINISH, 8'h00); // already full
    send_word(OP_KEY, "Q");      // square full
    send_word(OP_CIPHER, " ");
  endtask

  // Clear drops a held letter; partial square reads stale cells
  task automatic test_held_and_partial();
    send_word(OP_CIPHER, "M");
    send_word(OP_CLEAR, 8'h00);
    send_word(OP_KEY, "B");
    send_word(OP_CIPHER, "b");
    send_word(OP_CIPHER, "Z");  // absent from the square
  endtask

  // Random sessions of key setup followed by cipher text
  task automatic test_random_traffic(input int upto, input bit with_idle);
    int n_key;
    int n_text;
    while (words_sent < upto) begin
      send_idle  = with_idle && ($urandom_range(0, 3) != 0);
      sink_stall = with_idle && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
        n_key = $urandom_range(0, 30);
        repeat (n_key) begin
          if ($urandom_range(0, 7) == 0) send_word(OP_KEY, noise_byte());
          else send_word(OP_KEY, letter_byte($urandom_range(0, ALPHA - 1)));
        end
        if ($urandom_range(0, 4) != 0) send_word(OP_FINISH, 8'($urandom_range(0, 255)));
      end
      n_text = $urandom_range(1, 12);
      repeat (n_text) begin
        case ($urandom_range(0, 19))
          0: send_word(OP_CIPHER, noise_byte());
          1: send_word(pfd_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          2: send_word(OP_CIPHER, letter_byte(square_pick()));
          default: begin
            send_word(OP_CIPHER, letter_byte(square_pick()));
            send_word(OP_CIPHER, letter_byte(square_pick()));
          end
        endcase
      end
    end
  endtask

  // Output backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (sink_stall && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 14);
    out_ready <= (stall_left == 0);
  end

  // Compare each plaintext word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (plain_q.size() == 0) begin
        report_mismatch("word with none pending", int'(out_data), -1);
      end else begin
        due_w = plain_q.pop_front();
        if (out_data.plain_letter !== due_w.plain_letter)
          report_mismatch("plain_letter", int'(out_data.plain_letter),
                          int'(due_w.plain_letter));
        if (out_data.last_of_pair !== due_w.last_of_pair)
          report_mismatch("last_of_pair", int'(out_data.last_of_pair),
                          int'(due_w.last_of_pair));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_alphabet_square();
    test_keyed_square();
    test_held_and_partial();
    test_random_traffic(words_sent + 340, 1'b1);
    test_random_traffic(words_sent + 60, 1'b0);
    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- playfair_decrypt_top.f -----
design/pfd_pkg.sv
design/pfd_ram.sv
design/pfd_ctrl.sv
design/pfd_dpath.sv
design/playfair_decrypt_top.sv
tb/tb_playfair_decrypt_top.sv
